// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the compressor project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every rising clock edge outside reset.
`define SKC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// An implication checked in the same way.
`define SKC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    `SKC_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// File: src/skc_pkg.sv
// ---------------------------------------------------------------------------
// Compressor package
// Constants, types and table builders shared by the compressor modules.
// ---------------------------------------------------------------------------
package skc_pkg;

    localparam int CHANNELS        = 2;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int ROM_SIZE        = 1 << TABLE_ADDR_BITS;
    localparam int CH_BITS         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [23:0] UNITY_GAIN   = 24'd8388608;
    localparam int          FLOOR_DB     = -35840;
    localparam int          KNEE_HALF    = 1536;
    localparam int          DB_PER_OCT   = 394566;
    localparam int          OCT_PER_DB   = 2786635;
    localparam int          THIRD_RECIP  = 174763;
    localparam int          RATIO_MIN    = 256;
    localparam int          RESET_RATIO  = 677;
    localparam int          SLOPE_RESET  = 65536 - (1 << 24) / RESET_RATIO;
    localparam int          DIV_STEPS    = 17;
    localparam int          DIV_REM_INIT = (1 << 24) >> DIV_STEPS;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_THRESHOLD,
        REG_RATIO,
        REG_ATTACK,
        REG_RELEASE
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIV, ST_ENV_MUL, ST_ENV_UPD, ST_NIBBLE, ST_BIT, ST_LOG_ROM,
        ST_LOG_MUL, ST_DB, ST_KNEE, ST_RED, ST_EXP, ST_EXP_ROM, ST_TARGET,
        ST_GAIN_MUL, ST_GAIN_UPD, ST_OUT_MUL, ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        STEP_NONE, STEP_LOAD, STEP_DIV, STEP_ENV_MUL, STEP_ENV_UPD, STEP_NIBBLE,
        STEP_BIT, STEP_LOG_ROM, STEP_LOG_MUL, STEP_DB, STEP_KNEE, STEP_RED,
        STEP_EXP, STEP_EXP_ROM, STEP_TARGET, STEP_GAIN_MUL, STEP_GAIN_UPD,
        STEP_OUT_MUL, STEP_OUT
    } step_t;

    typedef struct packed {
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic div_req;
        logic div_last;
        logic out_busy;
    } status_t;

    typedef logic [15:0] log_rom_t [ROM_SIZE];
    typedef logic [23:0] exp_rom_t [ROM_SIZE];

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned res;
        longint unsigned bit_v;
        longint unsigned rem;
        res   = 0;
        bit_v = 64'd1 << 62;
        rem   = v;
        while (bit_v > rem) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic log_rom_t build_log_rom();
        log_rom_t        rom;
        longint unsigned x;
        logic [15:0]     frac;
        for (int i = 0; i < ROM_SIZE; i++) begin
            x    = longint'(ROM_SIZE + i) << (30 - TABLE_ADDR_BITS);
            frac = '0;
            for (int k = 0; k < 16; k++) begin
                x    = (x * x) >> 30;
                frac = {frac[14:0], 1'b0};
                if (x >= (64'd1 << 31)) begin
                    frac[0] = 1'b1;
                    x       = x >> 1;
                end
            end
            rom[i] = frac;
        end
        return rom;
    endfunction

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t        rom;
        longint unsigned root [17];
        longint unsigned acc;
        root[0] = 0;
        root[1] = isqrt64(64'd1 << 59);
        for (int k = 2; k <= 16; k++) root[k] = isqrt64(root[k-1] << 30);
        for (int i = 0; i < ROM_SIZE; i++) begin
            acc = 64'd1 << 30;
            for (int j = 0; j < TABLE_ADDR_BITS; j++) begin
                if (((i >> j) & 1) != 0) begin
                    acc = (acc * root[TABLE_ADDR_BITS - j] + (64'd1 << 29)) >> 30;
                end
            end
            rom[i] = 24'((acc + 64) >> 7);
        end
        return rom;
    endfunction

endpackage

// File: src/skc_ctrl.sv
// ---------------------------------------------------------------------------
// Compressor controller
// Sequences the datapath through one request and through the slope divide.
// ---------------------------------------------------------------------------
module skc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  skc_pkg::status_t  status,
    output skc_pkg::cmd_t     cmd
);

    skc_pkg::state_t state_reg;
    skc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.step   = skc_pkg::STEP_NONE;
        unique case (state_reg)
            skc_pkg::ST_IDLE: begin
                s_tready = !status.div_req;
                if (status.div_req) begin
                    state_next = skc_pkg::ST_DIV;
                end else if (s_tvalid) begin
                    cmd.step   = skc_pkg::STEP_LOAD;
                    state_next = skc_pkg::ST_ENV_MUL;
                end
            end
            skc_pkg::ST_DIV: begin
                cmd.step = skc_pkg::STEP_DIV;
                if (status.div_last) state_next = skc_pkg::ST_IDLE;
            end
            skc_pkg::ST_ENV_MUL: begin
                cmd.step   = skc_pkg::STEP_ENV_MUL;
                state_next = skc_pkg::ST_ENV_UPD;
            end
            skc_pkg::ST_ENV_UPD: begin
                cmd.step   = skc_pkg::STEP_ENV_UPD;
                state_next = skc_pkg::ST_NIBBLE;
            end
            skc_pkg::ST_NIBBLE: begin
                cmd.step   = skc_pkg::STEP_NIBBLE;
                state_next = skc_pkg::ST_BIT;
            end
            skc_pkg::ST_BIT: begin
                cmd.step   = skc_pkg::STEP_BIT;
                state_next = skc_pkg::ST_LOG_ROM;
            end
            skc_pkg::ST_LOG_ROM: begin
                cmd.step   = skc_pkg::STEP_LOG_ROM;
                state_next = skc_pkg::ST_LOG_MUL;
            end
            skc_pkg::ST_LOG_MUL: begin
                cmd.step   = skc_pkg::STEP_LOG_MUL;
                state_next = skc_pkg::ST_DB;
            end
            skc_pkg::ST_DB: begin
                cmd.step   = skc_pkg::STEP_DB;
                state_next = skc_pkg::ST_KNEE;
            end
            skc_pkg::ST_KNEE: begin
                cmd.step   = skc_pkg::STEP_KNEE;
                state_next = skc_pkg::ST_RED;
            end
            skc_pkg::ST_RED: begin
                cmd.step   = skc_pkg::STEP_RED;
                state_next = skc_pkg::ST_EXP;
            end
            skc_pkg::ST_EXP: begin
                cmd.step   = skc_pkg::STEP_EXP;
                state_next = skc_pkg::ST_EXP_ROM;
            end
            skc_pkg::ST_EXP_ROM: begin
                cmd.step   = skc_pkg::STEP_EXP_ROM;
                state_next = skc_pkg::ST_TARGET;
            end
            skc_pkg::ST_TARGET: begin
                cmd.step   = skc_pkg::STEP_TARGET;
                state_next = skc_pkg::ST_GAIN_MUL;
            end
            skc_pkg::ST_GAIN_MUL: begin
                cmd.step   = skc_pkg::STEP_GAIN_MUL;
                state_next = skc_pkg::ST_GAIN_UPD;
            end
            skc_pkg::ST_GAIN_UPD: begin
                cmd.step   = skc_pkg::STEP_GAIN_UPD;
                state_next = skc_pkg::ST_OUT_MUL;
            end
            skc_pkg::ST_OUT_MUL: begin
                cmd.step   = skc_pkg::STEP_OUT_MUL;
                state_next = skc_pkg::ST_OUT;
            end
            skc_pkg::ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.step   = skc_pkg::STEP_OUT;
                    state_next = skc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = skc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/skc_datapath.sv
// ---------------------------------------------------------------------------
// Compressor datapath
// Envelope, level, knee, gain tables, gain smoothing and the output register.
// ---------------------------------------------------------------------------
module skc_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [skc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [skc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic [23:0]                       s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,
    output logic                              m_tuser,
    input  skc_pkg::cmd_t                     cmd,
    output skc_pkg::status_t                  status
);

    localparam int B = skc_pkg::TABLE_ADDR_BITS;
    localparam skc_pkg::log_rom_t LOG_ROM = skc_pkg::build_log_rom();
    localparam skc_pkg::exp_rom_t EXP_ROM = skc_pkg::build_exp_rom();

    logic signed [15:0] thr_reg;
    logic [13:0]        ratio_reg;
    logic [23:0]        attack_reg;
    logic [23:0]        release_reg;
    logic [15:0]        slope_reg;
    logic [14:0]        rem_reg;
    logic [16:0]        quo_reg;
    logic [4:0]         div_cnt_reg;

    logic [23:0] level_reg [skc_pkg::CHANNELS];
    logic [23:0] gain_reg  [skc_pkg::CHANNELS];

    logic signed [23:0]           sample_reg;
    logic                         sel_reg;
    logic [skc_pkg::CH_BITS-1:0]  ch_reg;
    logic [23:0]                  mag_reg;
    logic [47:0]                  env_prod_reg;
    logic                         env_up_reg;
    logic [23:0]                  env_reg;
    logic [2:0]                   nib_reg;
    logic [23:0]                  shift_reg;
    logic [4:0]                   pos_reg;
    logic [B-1:0]                 log_idx_reg;
    logic [15:0]                  log_data_reg;
    logic signed [42:0]           lprod_reg;
    logic signed [17:0]           over_reg;
    logic                         below_reg;
    logic [32:0]                  ovsl_reg;
    logic [16:0]                  knee_reg;
    logic [17:0]                  red_reg;
    logic [23:0]                  e_reg;
    logic [23:0]                  exp_data_reg;
    logic [23:0]                  tg_reg;
    logic [47:0]                  g_prod_reg;
    logic                         g_up_reg;
    logic [23:0]                  g_reg;
    logic [47:0]                  out_prod_reg;
    logic                         m_tvalid_reg;
    logic [23:0]                  sample_out_reg;
    logic [23:0]                  gain_out_reg;
    logic                         chan_out_reg;

    logic [14:0]                  rem_shift;
    logic [14:0]                  rem_next;
    logic [16:0]                  quo_next;
    logic [13:0]                  ratio_eff;
    logic [16:0]                  slope_wide;
    logic [skc_pkg::CH_BITS-1:0]  ch_next;
    logic [23:0]                  mag_next;
    logic [23:0]                  env_old;
    logic [23:0]                  env_diff;
    logic [47:0]                  env_prod_next;
    logic [23:0]                  env_next;
    logic [2:0]                   nib_next;
    logic [23:0]                  shift_next;
    logic [1:0]                   bit_sel;
    logic [23:0]                  norm;
    logic signed [6:0]            pos_off;
    logic signed [22:0]           l_val;
    logic signed [42:0]           lprod_next;
    logic [42:0]                  lprod_mag;
    logic [18:0]                  db_mag;
    logic signed [16:0]           db_val;
    logic signed [17:0]           over_next;
    logic [11:0]                  knee_x;
    logic [35:0]                  knee_prod;
    logic [16:0]                  knee_next;
    logic [32:0]                  ovsl_next;
    logic [49:0]                  red_prod;
    logic [39:0]                  e_prod;
    logic [7:0]                   e_int;
    logic [23:0]                  tg_next;
    logic [23:0]                  g_old;
    logic [23:0]                  g_diff;
    logic [23:0]                  g_coef;
    logic [47:0]                  g_prod_next;
    logic [23:0]                  g_next;
    logic [24:0]                  y_mag;
    logic [23:0]                  y_next;

    always_comb begin
        rem_shift     = {rem_reg[13:0], 1'b0};
        ratio_eff     = (ratio_reg < 14'(skc_pkg::RATIO_MIN)) ?
                        14'(skc_pkg::RATIO_MIN) : ratio_reg;
        if (rem_shift >= {1'b0, ratio_eff}) begin
            rem_next = rem_shift - {1'b0, ratio_eff};
            quo_next = {quo_reg[15:0], 1'b1};
        end else begin
            rem_next = rem_shift;
            quo_next = {quo_reg[15:0], 1'b0};
        end
        slope_wide    = 17'd65536 - quo_next;

        ch_next       = (skc_pkg::CHANNELS == 1) ? '0 : skc_pkg::CH_BITS'(s_tuser);
        mag_next      = s_tdata[23] ? 24'(24'd0 - s_tdata) : s_tdata;

        env_old       = level_reg[ch_reg];
        env_diff      = (mag_reg > env_old) ? mag_reg - env_old : env_old - mag_reg;
        env_prod_next = 48'(env_diff) * 48'((mag_reg > env_old) ? attack_reg : release_reg);
        env_next      = env_up_reg ? env_old + env_prod_reg[47:24]
                                   : env_old - env_prod_reg[47:24];

        nib_next = 3'd0;
        for (int i = 0; i < 6; i++) begin
            if (env_reg[4*i +: 4] != 4'd0) nib_next = 3'(i);
        end
        shift_next = env_reg << {3'd5 - nib_next, 2'b00};

        bit_sel = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (shift_reg[20+i]) bit_sel = 2'(i);
        end
        norm = shift_reg << (2'd3 - bit_sel);

        pos_off    = $signed({2'b00, pos_reg}) - 7'sd22;
        l_val      = $signed({pos_off, 16'h0000}) + $signed({7'd0, log_data_reg});
        lprod_next = l_val * 20'sd394566;

        lprod_mag = lprod_reg[42] ? 43'(-lprod_reg) : 43'(lprod_reg);
        db_mag    = 19'((lprod_mag + 43'd8388608) >> 24);
        if (env_reg == 24'd0) begin
            db_val = 17'(skc_pkg::FLOOR_DB);
        end else if (lprod_reg[42]) begin
            db_val = 17'(-$signed({1'b0, db_mag[15:0]}));
        end else begin
            db_val = $signed({1'b0, db_mag[15:0]});
        end
        over_next = 18'(db_val) - 18'(thr_reg);

        knee_x    = 12'(over_reg[11:0] + 12'(skc_pkg::KNEE_HALF));
        knee_prod = 36'({knee_x, 6'b000000}) * 36'(skc_pkg::THIRD_RECIP);
        knee_next = (over_reg >= 18'sd1536) ? 17'd65536 : knee_prod[35:19];
        ovsl_next = 33'(over_reg[16:0]) * 33'(slope_reg);

        red_prod = 50'(ovsl_reg) * 50'(knee_reg) + 50'(64'd1 << 31);
        e_prod   = 40'(red_reg) * 40'(skc_pkg::OCT_PER_DB) + 40'd32768;

        e_int = e_reg[23:16];
        if (below_reg) begin
            tg_next = skc_pkg::UNITY_GAIN;
        end else if (e_int >= 8'd24) begin
            tg_next = 24'd0;
        end else begin
            tg_next = exp_data_reg >> e_int;
        end

        g_old       = gain_reg[ch_reg];
        g_diff      = (tg_reg > g_old) ? tg_reg - g_old : g_old - tg_reg;
        g_coef      = (tg_reg < g_old) ? attack_reg : release_reg;
        g_prod_next = 48'(g_diff) * 48'(g_coef);
        g_next      = g_up_reg ? g_old + g_prod_reg[47:24] : g_old - g_prod_reg[47:24];

        y_mag = 25'((out_prod_reg + 48'd4194304) >> 23);
        if (sample_reg[23]) begin
            y_next = (y_mag > 25'd8388608) ? 24'h800000 : 24'(25'd0 - y_mag);
        end else begin
            y_next = (y_mag > 25'd8388607) ? 24'h7FFFFF : y_mag[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= 16'sd0 - 16'sd2191;
            ratio_reg   <= 14'(skc_pkg::RESET_RATIO);
            attack_reg  <= 24'd87158;
            release_reg <= 24'd3883;
            slope_reg   <= 16'(skc_pkg::SLOPE_RESET);
        end else begin
            if (cfg_wr_en) begin
                unique case (skc_pkg::cfg_reg_t'(cfg_addr))
                    skc_pkg::REG_THRESHOLD: thr_reg     <= $signed(cfg_wr_data[15:0]);
                    skc_pkg::REG_RATIO:     ratio_reg   <= cfg_wr_data[13:0];
                    skc_pkg::REG_ATTACK:    attack_reg  <= cfg_wr_data;
                    skc_pkg::REG_RELEASE:   release_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.step == skc_pkg::STEP_DIV && div_cnt_reg == 5'd0) begin
                slope_reg <= slope_wide[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cfg_wr_en && skc_pkg::cfg_reg_t'(cfg_addr) == skc_pkg::REG_RATIO) begin
            rem_reg     <= 15'(skc_pkg::DIV_REM_INIT);
            quo_reg     <= '0;
            div_cnt_reg <= 5'(skc_pkg::DIV_STEPS - 1);
        end else if (cmd.step == skc_pkg::STEP_DIV) begin
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            div_cnt_reg <= div_cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < skc_pkg::CHANNELS; c++) begin
                level_reg[c] <= '0;
                gain_reg[c]  <= skc_pkg::UNITY_GAIN;
            end
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.step == skc_pkg::STEP_ENV_UPD) level_reg[ch_reg] <= env_next;
            if (cmd.step == skc_pkg::STEP_GAIN_UPD) gain_reg[ch_reg] <= g_next;
            if (cmd.step == skc_pkg::STEP_OUT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.step)
            skc_pkg::STEP_LOAD: begin
                sample_reg <= $signed(s_tdata);
                sel_reg    <= s_tuser;
                ch_reg     <= ch_next;
                mag_reg    <= mag_next;
            end
            skc_pkg::STEP_ENV_MUL: begin
                env_prod_reg <= env_prod_next;
                env_up_reg   <= mag_reg > env_old;
            end
            skc_pkg::STEP_ENV_UPD: env_reg <= env_next;
            skc_pkg::STEP_NIBBLE: begin
                nib_reg   <= nib_next;
                shift_reg <= shift_next;
            end
            skc_pkg::STEP_BIT: begin
                pos_reg     <= {nib_reg, 2'b00} + {3'd0, bit_sel};
                log_idx_reg <= norm[22 -: B];
            end
            skc_pkg::STEP_LOG_ROM: log_data_reg <= LOG_ROM[log_idx_reg];
            skc_pkg::STEP_LOG_MUL: lprod_reg <= lprod_next;
            skc_pkg::STEP_DB:      over_reg <= over_next;
            skc_pkg::STEP_KNEE: begin
                below_reg <= over_reg <= 18'sd0;
                knee_reg  <= knee_next;
                ovsl_reg  <= ovsl_next;
            end
            skc_pkg::STEP_RED:     red_reg <= red_prod[49:32];
            skc_pkg::STEP_EXP:     e_reg <= e_prod[39:16];
            skc_pkg::STEP_EXP_ROM: exp_data_reg <= EXP_ROM[e_reg[15 -: B]];
            skc_pkg::STEP_TARGET:  tg_reg <= tg_next;
            skc_pkg::STEP_GAIN_MUL: begin
                g_prod_reg <= g_prod_next;
                g_up_reg   <= tg_reg > g_old;
            end
            skc_pkg::STEP_GAIN_UPD: g_reg <= g_next;
            skc_pkg::STEP_OUT_MUL:  out_prod_reg <= 48'(mag_reg) * 48'(g_reg);
            skc_pkg::STEP_OUT: begin
                sample_out_reg <= y_next;
                gain_out_reg   <= g_reg;
                chan_out_reg   <= sel_reg;
            end
            default: ;
        endcase
    end

    assign status.div_req  = cfg_wr_en &&
                             skc_pkg::cfg_reg_t'(cfg_addr) == skc_pkg::REG_RATIO;
    assign status.div_last = div_cnt_reg == 5'd0;
    assign status.out_busy = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {gain_out_reg, sample_out_reg};
    assign m_tuser  = chan_out_reg;

endmodule

// File: src/soft_knee_compressor.sv
// ---------------------------------------------------------------------------
// Soft knee compressor
// Feed-forward compressor with per-channel envelope and gain smoothing.
// ---------------------------------------------------------------------------
// Each request on the s_ channel carries one Q2.22 sample in s_tdata and its
// channel number in s_tuser. The m_ channel returns one result per request:
// the compressed sample and the smoothed Q1.23 gain in m_tdata, and the
// channel in m_tuser.
// A request is worked through from acceptance to m_tvalid by the
// controller walking one shared datapath through the envelope update, the
// log table, the knee, the gain table and the gain update. A new request is
// accepted only once the controller is back in idle, so a request is not
// taken before the last one is through.
// A write of the ratio register in idle starts a slope divide, during
// which s_tready is low.
// Reset clears the envelopes to zero, the gains to unity and the registers
// to their defaults. The result sits in an output register; when the
// receiver stalls it holds, and the next request is still accepted and
// worked through, waiting only at its final step.
// ---------------------------------------------------------------------------
module soft_knee_compressor (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [skc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [skc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // sample_in
    input  logic                              s_tuser,   // channel_sel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,   // sample_out, applied_gain
    output logic                              m_tuser    // channel_out
);

    skc_pkg::cmd_t    cmd;
    skc_pkg::status_t status;

    skc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    skc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// File: src/skc_checker.sv
// ---------------------------------------------------------------------------
// Compressor checker
// Port-level assertions on the compressor, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module skc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    `SKC_ASSERT_IMPLIES(a_stall_valid, aclk, aresetn, m_tvalid && !m_tready, ##1 m_tvalid, "Result dropped while stalled.")
    `SKC_ASSERT_IMPLIES(a_stall_data, aclk, aresetn, m_tvalid && !m_tready, ##1 ($stable(m_tdata) && $stable(m_tuser)), "Result changed while stalled.")
    `SKC_ASSERT_IMPLIES(a_gain_range, aclk, aresetn, m_tvalid, m_tdata[47:24] <= 24'd8388608, "Gain above unity.")
    `SKC_ASSERT_IMPLIES(a_reset_quiet, aclk, aresetn, !$past(aresetn), !m_tvalid, "Result present after reset.")

endmodule

bind soft_knee_compressor skc_checker u_skc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: sim/soft_knee_compressor_tb.sv
// ---------------------------------------------------------------------------
// Soft knee compressor testbench
// Sends sample requests with random gaps and receiver stalls. Each request is
// run through a cycle-free model of the envelope, knee and gain path. Every
// result is then checked field by field against the oldest predicted result.
// ---------------------------------------------------------------------------
module soft_knee_compressor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [23:0] sample;
        logic        chan;
        logic [23:0] gain;
    } comp_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [skc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [skc_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [23:0]                    s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [47:0]                    m_tdata;
    logic                           m_tuser;

    comp_result_t    expected_q [$];
    int              errors = 0;
    bit              steady = 1'b0;
    bit              hold_rx = 1'b0;

    logic [15:0]     log2_tab [1024];
    logic [23:0]     pow2_tab [1024];
    longint          thr_q88;
    longint unsigned ratio_q88, atk_q24, rel_q24;
    longint unsigned env_st [2];
    longint unsigned gain_st [2];

    soft_knee_compressor u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
        .cfg_wr_data(cfg_wr_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd1 << 31;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic void build_tables();
        longint unsigned r [17];
        longint unsigned x, acc;
        logic [15:0]     f;
        r[1] = floor_sqrt(64'd1 << 59);
        for (int k = 2; k <= 16; k++) r[k] = floor_sqrt(r[k-1] << 30);
        for (int i = 0; i < 1024; i++) begin
            x = longint'(1024 + i) << 20;
            f = '0;
            for (int k = 0; k < 16; k++) begin
                x = (x * x) >> 30;
                f = {f[14:0], 1'b0};
                if (x >= (64'd1 << 31)) begin
                    f[0] = 1'b1;
                    x = x >> 1;
                end
            end
            log2_tab[i] = f;
            acc = 64'd1 << 30;
            for (int j = 0; j < 10; j++)
                if (i[j]) acc = (acc * r[10 - j] + (64'd1 << 29)) >> 30;
            pow2_tab[i] = 24'((acc + 64) >> 7);
        end
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint unsigned smooth(longint unsigned cur, longint unsigned tgt,
                                               longint unsigned coef);
        if (tgt > cur) return cur + (((tgt - cur) * coef) >> 24);
        return cur - (((cur - tgt) * coef) >> 24);
    endfunction

    function automatic longint env_to_db(longint unsigned env);
        int              p;
        longint unsigned idx;
        longint          lg;
        if (env == 0) return skc_pkg::FLOOR_DB;
        p = 23;
        while (env[p] == 1'b0) p--;
        if (p >= 10) idx = (env >> (p - 10)) & 1023;
        else idx = (env << (10 - p)) & 1023;
        lg = longint'(p - 22) * 65536 + longint'(log2_tab[idx]);
        return round_shift(lg * skc_pkg::DB_PER_OCT, 24);
    endfunction

    function automatic longint unsigned knee_gain(longint over);
        longint unsigned knee, slope, red, e, n, r;
        if (over <= 0) return skc_pkg::UNITY_GAIN;
        r = (ratio_q88 < 256) ? 256 : ratio_q88;
        knee = (longint'(over + skc_pkg::KNEE_HALF) << 16) / 3072;
        if (knee > 65536) knee = 65536;
        slope = 65536 - ((64'd1 << 24) / r);
        red = (longint'(over) * slope * knee + (64'd1 << 31)) >> 32;
        e = (red * skc_pkg::OCT_PER_DB + 32768) >> 16;
        n = e >> 16;
        if (n >= 24) return 0;
        return longint'(pow2_tab[(e & 16'hFFFF) >> 6]) >> n;
    endfunction

    function automatic comp_result_t compress(logic [23:0] smp, logic ch);
        comp_result_t    res;
        longint          s, y;
        longint unsigned mag, tg;
        s = longint'($signed(smp));
        mag = (s < 0) ? -s : s;
        env_st[ch] = smooth(env_st[ch], mag, (mag > env_st[ch]) ? atk_q24 : rel_q24);
        tg = knee_gain(env_to_db(env_st[ch]) - thr_q88);
        gain_st[ch] = smooth(gain_st[ch], tg, (tg < gain_st[ch]) ? atk_q24 : rel_q24);
        y = round_shift(s * longint'(gain_st[ch]), 23);
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        res.sample = y[23:0];
        res.chan = ch;
        res.gain = gain_st[ch][23:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn || hold_rx) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge aclk) begin
        comp_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result: sample_out %h", m_tdata[23:0]);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (m_tdata[23:0] !== exp_r.sample) begin
                    $error("sample_out expected %h actual %h", exp_r.sample, m_tdata[23:0]);
                    errors++;
                end
                if (m_tdata[47:24] !== exp_r.gain) begin
                    $error("applied_gain expected %h actual %h", exp_r.gain, m_tdata[47:24]);
                    errors++;
                end
                if (m_tuser !== exp_r.chan) begin
                    $error("channel_out expected %b actual %b", exp_r.chan, m_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic send_sample(logic [23:0] smp, logic ch);
        if (!steady && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tuser <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(compress(smp, ch));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_reg(skc_pkg::cfg_reg_t idx, logic [23:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            skc_pkg::REG_THRESHOLD: thr_q88 = longint'($signed(val[15:0]));
            skc_pkg::REG_RATIO:     ratio_q88 = val[13:0];
            skc_pkg::REG_ATTACK:    atk_q24 = val;
            skc_pkg::REG_RELEASE:   rel_q24 = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'($urandom_range(255));
            1: return -24'($urandom_range(4095));
            2: return 24'(8388608 - $urandom_range(65535));
            3: return 24'($urandom_range(8388607, 6000000));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [23:0] edge_vals [6] = '{24'h7FFFFF, 24'h800000, 24'h000000,
                                      24'h000001, 24'hFFFFFF, 24'h400000};
        foreach (edge_vals[i]) send_sample(edge_vals[i], i[0]);
        write_reg(skc_pkg::REG_ATTACK, 24'hFFFFFF);
        write_reg(skc_pkg::REG_RELEASE, 24'hFFFFFF);
        write_reg(skc_pkg::REG_THRESHOLD, 24'(-24576));
        write_reg(skc_pkg::REG_RATIO, 24'd8192);
        for (int i = 0; i < 4; i++) send_sample(i[0] ? 24'h7FFFFF : 24'h800000, i[1]);
        send_sample(24'h000000, 1'b0);
        write_reg(skc_pkg::REG_RATIO, 24'd0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h000010, 1'b1);
        write_reg(skc_pkg::REG_RATIO, 24'd512);
        write_reg(skc_pkg::REG_THRESHOLD, 24'd3072);
        send_sample(24'h7FFFFF, 1'b1);
        write_reg(skc_pkg::REG_ATTACK, 24'd0);
        write_reg(skc_pkg::REG_RELEASE, 24'd0);
        send_sample(24'h123456, 1'b0);
        send_sample(24'h800000, 1'b1);
        write_reg(skc_pkg::REG_ATTACK, 24'd1);
        write_reg(skc_pkg::REG_RELEASE, 24'd1);
        send_sample(24'h7FFFFF, 1'b0);
    endtask

    task automatic test_backpressure();
        write_reg(skc_pkg::REG_THRESHOLD, 24'(-2191));
        write_reg(skc_pkg::REG_RATIO, 24'd677);
        write_reg(skc_pkg::REG_ATTACK, 24'd87158);
        write_reg(skc_pkg::REG_RELEASE, 24'd3883);
        hold_rx = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_rx = 1'b0;
            end
        join_none
        for (int i = 0; i < 20; i++) send_sample(rand_sample(), 1'($urandom));
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(skc_pkg::REG_THRESHOLD, 24'($urandom_range(27648) - 24576));
            write_reg(skc_pkg::REG_RATIO, 24'($urandom_range(8192)));
            write_reg(skc_pkg::REG_ATTACK,
                      24'($urandom_range(24'hFFFFFF, 1) >> $urandom_range(12)));
            write_reg(skc_pkg::REG_RELEASE,
                      24'($urandom_range(24'hFFFFFF, 1) >> $urandom_range(16)));
            steady = (ph == 2);
            for (int i = 0; i < 165; i++) send_sample(rand_sample(), 1'($urandom));
            steady = 1'b0;
        end
    endtask

    initial begin
        build_tables();
        thr_q88 = -2191;
        ratio_q88 = 677;
        atk_q24 = 87158;
        rel_q24 = 3883;
        for (int c = 0; c < 2; c++) begin
            env_st[c] = 0;
            gain_st[c] = skc_pkg::UNITY_GAIN;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random();
        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
